FILE: src/rvm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvm_pkg: shared types and constants for the instruction core
// Holds operation codes, fault codes, controller commands and sizes.
// ----------------------------------------------------------------------------
package rvm_pkg;

    localparam int MEM_DEPTH     = 4096;
    localparam int MEM_AW        = $clog2(MEM_DEPTH);
    localparam int STACK_DEPTH   = 16;
    localparam int STACK_AW      = $clog2(STACK_DEPTH);
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int ROW_AW        = $clog2(SCREEN_HEIGHT);

    typedef enum logic [1:0] {
        OP_EXEC  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_OPC   = 2'd1,
        FAULT_OVER  = 2'd2,
        FAULT_UNDER = 2'd3
    } fault_t;

    // Multi-cycle datapath jobs
    typedef enum logic [2:0] {
        JOB_NONE  = 3'd0,
        JOB_CLEAR = 3'd1,
        JOB_DRAW  = 3'd2,
        JOB_BCD   = 3'd3,
        JOB_SAVE  = 3'd4,
        JOB_LOAD  = 3'd5
    } job_t;

    // Controller to datapath
    typedef struct packed {
        logic launch;   // capture item and run the part done at launch
        logic step;     // run one step of the current job
        logic finish;   // commit job end and register result
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        job_t job;      // job chosen by the launched item
        logic last;     // current step is the final one
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: src/rvm_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvm_datapath: machine state and execution units
// Registers, stack, memory, display rows and timers; runs simple
// opcodes at launch and walks memory or display one step per cycle.
// ----------------------------------------------------------------------------
module rvm_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rvm_pkg::dp_cmd_t  cmd,
    output rvm_pkg::dp_stat_t      stat,
    input  wire logic [1:0]        operation,
    input  wire logic [15:0]       opcode,
    input  wire logic [7:0]        random_byte,
    input  wire logic [11:0]       address,
    input  wire logic [7:0]        write_data,
    output logic                   done,
    output logic [11:0]            program_counter,
    output logic [1:0]             fault,
    output logic [63:0]            row_pixels,
    output logic                   sound_on,
    output logic                   screen_changed
);

    // Architectural state
    logic [7:0]  v_reg [16];
    logic [15:0] i_reg;
    logic [11:0] pc_reg;
    logic [11:0] stk_mem [rvm_pkg::STACK_DEPTH];
    logic [rvm_pkg::STACK_AW:0] sp_reg;
    logic [7:0]  dt_reg, st_reg;
    logic [63:0] pix_reg [rvm_pkg::SCREEN_HEIGHT];
    logic [7:0]  mem [rvm_pkg::MEM_DEPTH];

    // Job state
    rvm_pkg::job_t job_reg;
    logic [4:0]  cnt_reg;       // step counter
    logic [3:0]  lim_reg;       // last step index
    logic [7:0]  vx_reg;
    logic [5:0]  xs_reg;
    logic [rvm_pkg::ROW_AW-1:0] ys_reg;
    logic        hit_reg;
    logic        rd_pend_reg;   // memory read data valid for this step
    logic [7:0]  rd_data_reg;
    logic [7:0]  bcd_h, bcd_t, bcd_o;

    // Decode fields
    logic [3:0] dx, dy, dn;
    logic [7:0] dnn, vx, vy;
    logic [11:0] dnnn, pc2, pc4;
    assign dx   = opcode[11:8];
    assign dy   = opcode[7:4];
    assign dn   = opcode[3:0];
    assign dnn  = opcode[7:0];
    assign dnnn = opcode[11:0];
    assign vx   = v_reg[dx];
    assign vy   = v_reg[dy];
    assign pc2  = pc_reg + 12'd2;
    assign pc4  = pc_reg + 12'd4;

    // Combinational decode of the launched item
    logic [11:0] pc_n;
    logic [1:0]  flt_n;
    rvm_pkg::job_t job_n;
    logic        wv_en, wf_en, chg_n;
    logic [3:0]  wv_idx;
    logic [7:0]  wv_dat, wf_dat;
    logic [8:0]  sum9;
    always_comb
    begin
        pc_n   = pc2;
        flt_n  = rvm_pkg::FAULT_NONE;
        job_n  = rvm_pkg::JOB_NONE;
        wv_en  = 1'b0;
        wf_en  = 1'b0;
        wv_idx = dx;
        wv_dat = 8'd0;
        wf_dat = 8'd0;
        chg_n  = 1'b0;
        sum9   = 9'd0;
        case (opcode[15:12])
            4'h0:
            begin
                if (opcode == 16'h00E0) begin
                    job_n = rvm_pkg::JOB_CLEAR;
                    chg_n = 1'b1;
                end else if (opcode == 16'h00EE) begin
                    if (sp_reg == '0) flt_n = rvm_pkg::FAULT_UNDER;
                    else pc_n = stk_mem[sp_reg[rvm_pkg::STACK_AW-1:0] - 1'b1] + 12'd2;
                end else flt_n = rvm_pkg::FAULT_OPC;
            end
            4'h1: pc_n = dnnn;
            4'h2:
            begin
                if (sp_reg == (rvm_pkg::STACK_AW+1)'(rvm_pkg::STACK_DEPTH))
                    flt_n = rvm_pkg::FAULT_OVER;
                else pc_n = dnnn;
            end
            4'h3: if (vx == dnn) pc_n = pc4;
            4'h4: if (vx != dnn) pc_n = pc4;
            4'h5:
            begin
                if (dn != 4'd0) flt_n = rvm_pkg::FAULT_OPC;
                else if (vx == vy) pc_n = pc4;
            end
            4'h6: begin wv_en = 1'b1; wv_dat = dnn; end
            4'h7: begin wv_en = 1'b1; wv_dat = vx + dnn; end
            4'h8:
            begin
                case (dn)
                    4'h0: begin wv_en = 1'b1; wv_dat = vy; end
                    4'h1: begin wv_en = 1'b1; wv_dat = vx | vy; end
                    4'h2: begin wv_en = 1'b1; wv_dat = vx & vy; end
                    4'h3: begin wv_en = 1'b1; wv_dat = vx ^ vy; end
                    4'h4:
                    begin
                        sum9 = {1'b0, vx} + {1'b0, vy};
                        wv_en = 1'b1; wv_dat = sum9[7:0];
                        wf_en = 1'b1; wf_dat = {7'd0, sum9[8]};
                    end
                    4'h5:
                    begin
                        wv_en = 1'b1; wv_dat = vx - vy;
                        wf_en = 1'b1; wf_dat = {7'd0, vx >= vy};
                    end
                    4'h6:
                    begin
                        wv_en = 1'b1; wv_dat = {1'b0, vx[7:1]};
                        wf_en = 1'b1; wf_dat = {7'd0, vx[0]};
                    end
                    4'h7:
                    begin
                        wv_en = 1'b1; wv_dat = vy - vx;
                        wf_en = 1'b1; wf_dat = {7'd0, vy >= vx};
                    end
                    4'hE:
                    begin
                        wv_en = 1'b1; wv_dat = {vx[6:0], 1'b0};
                        wf_en = 1'b1; wf_dat = {7'd0, vx[7]};
                    end
                    default: flt_n = rvm_pkg::FAULT_OPC;
                endcase
            end
            4'h9:
            begin
                if (dn != 4'd0) flt_n = rvm_pkg::FAULT_OPC;
                else if (vx != vy) pc_n = pc4;
            end
            4'hA: ;
            4'hB: pc_n = dnnn + {4'd0, v_reg[0]};
            4'hC: begin wv_en = 1'b1; wv_dat = random_byte & dnn; end
            4'hD:
            begin
                chg_n = 1'b1;
                if (dn == 4'd0) begin
                    wf_en = 1'b1; wf_dat = 8'd0;
                end else job_n = rvm_pkg::JOB_DRAW;
            end
            4'hE: if (dnn != 8'h9E && dnn != 8'hA1) flt_n = rvm_pkg::FAULT_OPC;
            default:
            begin
                case (dnn)
                    8'h07: begin wv_en = 1'b1; wv_dat = dt_reg; end
                    8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29: ;
                    8'h33: job_n = rvm_pkg::JOB_BCD;
                    8'h55: job_n = rvm_pkg::JOB_SAVE;
                    8'h65: job_n = rvm_pkg::JOB_LOAD;
                    default: flt_n = rvm_pkg::FAULT_OPC;
                endcase
            end
        endcase
        if (flt_n != rvm_pkg::FAULT_NONE) begin
            job_n = rvm_pkg::JOB_NONE;
            wv_en = 1'b0;
            wf_en = 1'b0;
            chg_n = 1'b0;
        end
    end

    logic is_exec;
    assign is_exec = (operation == rvm_pkg::OP_EXEC);

    // BCD digits of the captured byte: compare and subtract for hundreds,
    // reciprocal multiply for tens
    logic [7:0]  bcd_rem;
    logic [15:0] bcd_prod;
    always_comb
    begin
        if (vx_reg >= 8'd200)
        begin
            bcd_h   = 8'd2;
            bcd_rem = vx_reg - 8'd200;
        end
        else if (vx_reg >= 8'd100)
        begin
            bcd_h   = 8'd1;
            bcd_rem = vx_reg - 8'd100;
        end
        else
        begin
            bcd_h   = 8'd0;
            bcd_rem = vx_reg;
        end
        bcd_prod = {8'd0, bcd_rem} * 16'd205;
        bcd_t    = {4'd0, bcd_prod[14:11]};
        bcd_o    = bcd_rem - ((bcd_t << 3) + (bcd_t << 1));
    end

    // Step addressing
    logic [rvm_pkg::MEM_AW-1:0] step_addr;
    logic [rvm_pkg::ROW_AW-1:0] draw_row;
    assign step_addr = rvm_pkg::MEM_AW'(i_reg + {11'd0, cnt_reg});
    assign draw_row  = ys_reg + cnt_reg[rvm_pkg::ROW_AW-1:0];

    // Draw step: steps with rd_pend set use read data; cnt walks rows via rd_pend
    logic [63:0] spr_mask;
    logic [63:0] spr_wide;
    assign spr_wide = {rd_data_reg, 56'd0};
    assign spr_mask = (spr_wide >> xs_reg) | (spr_wide << (7'd64 - {1'b0, xs_reg}));

    // Status: job of the presented item and end of the current walk
    always_comb
    begin
        stat.job = is_exec ? job_n : rvm_pkg::JOB_NONE;
        case (job_reg)
            rvm_pkg::JOB_CLEAR: stat.last = (cnt_reg == 5'(rvm_pkg::SCREEN_HEIGHT - 1));
            rvm_pkg::JOB_BCD:   stat.last = (cnt_reg == 5'd2);
            rvm_pkg::JOB_SAVE:  stat.last = (cnt_reg == {1'b0, lim_reg});
            rvm_pkg::JOB_DRAW,
            rvm_pkg::JOB_LOAD:  stat.last = rd_pend_reg && (cnt_reg == {1'b0, lim_reg});
            default:            stat.last = 1'b1;
        endcase
    end

    // Memory port: one write and one registered read per cycle
    logic        mw_en;
    logic [rvm_pkg::MEM_AW-1:0] mw_addr;
    logic [7:0]  mw_dat;
    always_comb
    begin
        mw_en   = 1'b0;
        mw_addr = step_addr;
        mw_dat  = 8'd0;
        if (cmd.launch && operation == rvm_pkg::OP_WRITE) begin
            mw_en = 1'b1;
            mw_addr = address[rvm_pkg::MEM_AW-1:0];
            mw_dat = write_data;
        end else if (cmd.step && job_reg == rvm_pkg::JOB_BCD) begin
            mw_en = 1'b1;
            mw_dat = (cnt_reg == 5'd0) ? bcd_h : ((cnt_reg == 5'd1) ? bcd_t : bcd_o);
        end else if (cmd.step && job_reg == rvm_pkg::JOB_SAVE) begin
            mw_en = 1'b1;
            mw_dat = v_reg[cnt_reg[3:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mw_en) mem[mw_addr] <= mw_dat;
        rd_data_reg <= mem[step_addr];
    end

    // Call stack storage
    always_ff @(posedge clk)
    begin
        if (cmd.launch && is_exec && opcode[15:12] == 4'h2 && flt_n == rvm_pkg::FAULT_NONE)
            stk_mem[sp_reg[rvm_pkg::STACK_AW-1:0]] <= pc_reg;
    end

    // Display rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int r = 0; r < rvm_pkg::SCREEN_HEIGHT; r++) pix_reg[r] <= '0;
        end else if (cmd.step && job_reg == rvm_pkg::JOB_CLEAR) begin
            pix_reg[cnt_reg[rvm_pkg::ROW_AW-1:0]] <= '0;
        end else if (cmd.step && job_reg == rvm_pkg::JOB_DRAW && rd_pend_reg) begin
            pix_reg[draw_row] <= pix_reg[draw_row] ^ spr_mask;
        end
    end

    // Control and register state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int r = 0; r < 16; r++) v_reg[r] <= 8'd0;
            i_reg       <= 16'd0;
            pc_reg      <= 12'h200;
            sp_reg      <= '0;
            dt_reg      <= 8'd0;
            st_reg      <= 8'd0;
            job_reg     <= rvm_pkg::JOB_NONE;
            cnt_reg     <= 5'd0;
            rd_pend_reg <= 1'b0;
            hit_reg     <= 1'b0;
            done        <= 1'b0;
            fault       <= rvm_pkg::FAULT_NONE;
            row_pixels  <= '0;
            screen_changed <= 1'b0;
            lim_reg     <= 4'd0;
            vx_reg      <= 8'd0;
            xs_reg      <= 6'd0;
            ys_reg      <= '0;
        end else begin
            done <= 1'b0;
            if (cmd.launch) begin
                cnt_reg     <= 5'd0;
                rd_pend_reg <= 1'b0;
                hit_reg     <= 1'b0;
                vx_reg      <= vx;
                xs_reg      <= vx[5:0];
                ys_reg      <= vy[rvm_pkg::ROW_AW-1:0];
                lim_reg     <= (opcode[15:12] == 4'hD) ? dn - 4'd1 : dx;
                job_reg     <= stat.job;
                fault       <= rvm_pkg::FAULT_NONE;
                row_pixels  <= '0;
                screen_changed <= 1'b0;
                case (operation)
                    rvm_pkg::OP_EXEC:
                    begin
                        fault <= flt_n;
                        screen_changed <= chg_n;
                        if (flt_n == rvm_pkg::FAULT_NONE) begin
                            pc_reg <= pc_n;
                            if (wv_en) v_reg[wv_idx] <= wv_dat;
                            if (wf_en) v_reg[15] <= wf_dat;
                            if (opcode[15:12] == 4'h2) sp_reg <= sp_reg + 1'b1;
                            if (opcode == 16'h00EE) sp_reg <= sp_reg - 1'b1;
                            if (opcode[15:12] == 4'hA) i_reg <= {4'd0, dnnn};
                            if (opcode[15:12] == 4'hF) begin
                                if (dnn == 8'h15) dt_reg <= vx;
                                if (dnn == 8'h18) st_reg <= vx;
                                if (dnn == 8'h1E) i_reg <= i_reg + {8'd0, vx};
                                if (dnn == 8'h29) i_reg <= {6'd0, vx, 2'd0} + {8'd0, vx};
                            end
                        end
                    end
                    rvm_pkg::OP_TICK:
                    begin
                        if (dt_reg != 8'd0) dt_reg <= dt_reg - 8'd1;
                        if (st_reg != 8'd0) st_reg <= st_reg - 8'd1;
                    end
                    rvm_pkg::OP_READ:
                    begin
                        if (address < 12'(rvm_pkg::SCREEN_HEIGHT))
                            row_pixels <= pix_reg[address[rvm_pkg::ROW_AW-1:0]];
                    end
                    default: ;
                endcase
            end else if (cmd.step) begin
                case (job_reg)
                    rvm_pkg::JOB_CLEAR, rvm_pkg::JOB_BCD, rvm_pkg::JOB_SAVE:
                        cnt_reg <= cnt_reg + 5'd1;
                    rvm_pkg::JOB_DRAW:
                    begin
                        // alternate: issue read, then apply row
                        rd_pend_reg <= !rd_pend_reg;
                        if (rd_pend_reg) begin
                            cnt_reg <= cnt_reg + 5'd1;
                            if ((pix_reg[draw_row] & spr_mask) != 64'd0) hit_reg <= 1'b1;
                        end
                    end
                    rvm_pkg::JOB_LOAD:
                    begin
                        rd_pend_reg <= !rd_pend_reg;
                        if (rd_pend_reg) begin
                            cnt_reg <= cnt_reg + 5'd1;
                            v_reg[cnt_reg[3:0]] <= rd_data_reg;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.finish) begin
                done    <= 1'b1;
                job_reg <= rvm_pkg::JOB_NONE;
                if (job_reg == rvm_pkg::JOB_DRAW)
                    v_reg[15] <= {7'd0, hit_reg};
            end
        end
    end

    assign program_counter = pc_reg;
    assign sound_on        = (st_reg != 8'd0);

endmodule
`default_nettype wire

FILE: src/rvm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvm_ctrl: sequencing state machine
// Accepts an item, steps the datapath job (if any) until its last step, then
// commits and strobes the result.
// ----------------------------------------------------------------------------
module rvm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output rvm_pkg::dp_cmd_t       cmd,
    input  wire rvm_pkg::dp_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    cmd.launch = 1'b1;
                    if (stat.job == rvm_pkg::JOB_NONE) cmd.finish = 1'b1;
                    else state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.step = 1'b1;
                if (stat.last) state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

FILE: src/retro_vm_instruction_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// retro_vm_instruction_core: CHIP-8 style instruction core
// Executes one opcode, memory write, timer tick or display row read per item.
//
// Usage: raise start with the item fields while busy is low; the item is
// transferred at that clock edge. One result follows, marked by done for a
// single cycle; the receiver cannot stall it. Simple opcodes, memory writes,
// ticks and row reads give done in the cycle after the transfer with busy low.
// Multi-step opcodes hold busy: clear (one display row per cycle), BCD,
// register save, register load and a sprite of N rows (one memory read and
// one row update per row over the single memory port). The next start may
// come in the cycle done is shown.
// Reset returns registers, display, timers and stack level to zero and PC
// to 0x200; memory and stack contents are not cleared.
// ----------------------------------------------------------------------------
module retro_vm_instruction_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [15:0] opcode,
    input  wire logic [7:0]  random_byte,
    input  wire logic [11:0] address,
    input  wire logic [7:0]  write_data,
    output logic             done,
    output logic [11:0]      program_counter,
    output logic [1:0]       fault,
    output logic [63:0]      row_pixels,
    output logic             sound_on,
    output logic             screen_changed
);

    rvm_pkg::dp_cmd_t  cmd;
    rvm_pkg::dp_stat_t stat;

    rvm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    rvm_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .operation       (operation),
        .opcode          (opcode),
        .random_byte     (random_byte),
        .address         (address),
        .write_data      (write_data),
        .done            (done),
        .program_counter (program_counter),
        .fault           (fault),
        .row_pixels      (row_pixels),
        .sound_on        (sound_on),
        .screen_changed  (screen_changed)
    );

endmodule
`default_nettype wire

FILE: bench/retro_vm_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retro_vm_core_checker: result predictor and comparator for the core
// Watches item transfers and done strobes, tracks the machine state,
// and compares every result field against the predicted value.
// ----------------------------------------------------------------------------
module retro_vm_core_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  operation,
    input  wire logic [15:0] opcode,
    input  wire logic [7:0]  random_byte,
    input  wire logic [11:0] address,
    input  wire logic [7:0]  write_data,
    input  wire logic        done,
    input  wire logic [11:0] program_counter,
    input  wire logic [1:0]  fault,
    input  wire logic [63:0] row_pixels,
    input  wire logic        sound_on,
    input  wire logic        screen_changed,
    output int               errors,
    output int               pending
);

    typedef struct {
        logic [11:0]     pc;
        rvm_pkg::fault_t flt;
        logic [63:0]     row;
        logic            snd;
        logic            chg;
    } core_result_t;

    core_result_t pending_results[$];

    // Machine state as predicted
    logic [7:0]  vregs [16];
    logic [15:0] index_reg;
    logic [11:0] pc_reg;
    logic [7:0]  memory [rvm_pkg::MEM_DEPTH];
    logic [63:0] screen [rvm_pkg::SCREEN_HEIGHT];
    logic [11:0] call_stack [rvm_pkg::STACK_DEPTH];
    int          stack_depth;
    logic [7:0]  delay_cnt;
    logic [7:0]  sound_cnt;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        errors++;
    endtask

    function automatic logic [11:0] mem_ix(input int k);
        return index_reg[11:0] + 12'(k);
    endfunction

    // XOR a sprite onto the screen, wrapping both edges
    task automatic draw_sprite(input logic [7:0] vx, input logic [7:0] vy,
                               input logic [3:0] rows);
        logic [5:0]  xs;
        logic [4:0]  ys;
        logic [4:0]  line;
        logic [5:0]  col;
        logic [7:0]  bits;
        logic [63:0] mask;
        logic        hit;
        xs  = vx[5:0];
        ys  = vy[4:0];
        hit = 1'b0;
        for (int r = 0; r < int'(rows); r++)
        begin
            line = ys + 5'(r);
            bits = memory[mem_ix(r)];
            mask = '0;
            for (int b = 0; b < 8; b++)
            begin
                if (bits[7-b])
                begin
                    col = xs + 6'(b);
                    mask[63 - int'(col)] = 1'b1;
                end
            end
            if ((screen[line] & mask) != 0)
                hit = 1'b1;
            screen[line] ^= mask;
        end
        vregs[15] = {7'd0, hit};
    endtask

    task automatic run_opcode(input logic [15:0] op, input logic [7:0] rnd,
                              output rvm_pkg::fault_t flt, output logic chg);
        logic [3:0]  x, y, n;
        logic [7:0]  nn, vx, vy, res;
        logic [11:0] nnn, npc, skp;
        logic [8:0]  sum;
        logic        flag, setf;
        x    = op[11:8];
        y    = op[7:4];
        n    = op[3:0];
        nn   = op[7:0];
        nnn  = op[11:0];
        vx   = vregs[x];
        vy   = vregs[y];
        npc  = pc_reg + 12'd2;
        skp  = pc_reg + 12'd4;
        flt  = rvm_pkg::FAULT_NONE;
        chg  = 1'b0;
        setf = 1'b0;
        res  = '0;
        flag = 1'b0;
        case (op[15:12])
            4'h0:
                if (op == 16'h00E0)
                begin
                    for (int k = 0; k < rvm_pkg::SCREEN_HEIGHT; k++)
                        screen[k] = '0;
                    chg = 1'b1;
                end
                else if (op == 16'h00EE)
                begin
                    if (stack_depth == 0)
                        flt = rvm_pkg::FAULT_UNDER;
                    else
                    begin
                        stack_depth--;
                        npc = call_stack[stack_depth] + 12'd2;
                    end
                end
                else
                    flt = rvm_pkg::FAULT_OPC;
            4'h1: npc = nnn;
            4'h2:
                if (stack_depth >= rvm_pkg::STACK_DEPTH)
                    flt = rvm_pkg::FAULT_OVER;
                else
                begin
                    call_stack[stack_depth] = pc_reg;
                    stack_depth++;
                    npc = nnn;
                end
            4'h3: if (vx == nn) npc = skp;
            4'h4: if (vx != nn) npc = skp;
            4'h5:
                if (n != 0)
                    flt = rvm_pkg::FAULT_OPC;
                else if (vx == vy)
                    npc = skp;
            4'h6: vregs[x] = nn;
            4'h7: vregs[x] = vx + nn;
            4'h8:
                case (n)
                    4'h0: vregs[x] = vy;
                    4'h1: vregs[x] = vx | vy;
                    4'h2: vregs[x] = vx & vy;
                    4'h3: vregs[x] = vx ^ vy;
                    4'h4:
                    begin
                        sum  = {1'b0, vx} + {1'b0, vy};
                        res  = sum[7:0];
                        flag = sum[8];
                        setf = 1'b1;
                    end
                    4'h5:
                    begin
                        res  = vx - vy;
                        flag = vx >= vy;
                        setf = 1'b1;
                    end
                    4'h6:
                    begin
                        res  = vx >> 1;
                        flag = vx[0];
                        setf = 1'b1;
                    end
                    4'h7:
                    begin
                        res  = vy - vx;
                        flag = vy >= vx;
                        setf = 1'b1;
                    end
                    4'hE:
                    begin
                        res  = vx << 1;
                        flag = vx[7];
                        setf = 1'b1;
                    end
                    default: flt = rvm_pkg::FAULT_OPC;
                endcase
            4'h9:
                if (n != 0)
                    flt = rvm_pkg::FAULT_OPC;
                else if (vx != vy)
                    npc = skp;
            4'hA: index_reg = {4'd0, nnn};
            4'hB: npc = nnn + {4'd0, vregs[0]};
            4'hC: vregs[x] = rnd & nn;
            4'hD:
            begin
                draw_sprite(vx, vy, n);
                chg = 1'b1;
            end
            4'hE:
                if (nn != 8'h9E && nn != 8'hA1)
                    flt = rvm_pkg::FAULT_OPC;
            default:
                case (nn)
                    8'h07: vregs[x] = delay_cnt;
                    8'h0A: ;
                    8'h15: delay_cnt = vx;
                    8'h18: sound_cnt = vx;
                    8'h1E: index_reg = index_reg + {8'd0, vx};
                    8'h29: index_reg = {8'd0, vx} * 16'd5;
                    8'h33:
                    begin
                        memory[mem_ix(0)] = vx / 8'd100;
                        memory[mem_ix(1)] = (vx / 8'd10) % 8'd10;
                        memory[mem_ix(2)] = vx % 8'd10;
                    end
                    8'h55:
                        for (int k = 0; k <= int'(x); k++)
                            memory[mem_ix(k)] = vregs[k];
                    8'h65:
                        for (int k = 0; k <= int'(x); k++)
                            vregs[k] = memory[mem_ix(k)];
                    default: flt = rvm_pkg::FAULT_OPC;
                endcase
        endcase
        // flag lands after the result so VF as target ends up holding it
        if (setf && flt == rvm_pkg::FAULT_NONE)
        begin
            vregs[x]  = res;
            vregs[15] = {7'd0, flag};
        end
        if (flt == rvm_pkg::FAULT_NONE)
            pc_reg = npc;
    endtask

    task automatic predict_item();
        core_result_t    r;
        rvm_pkg::fault_t flt;
        logic            chg;
        flt   = rvm_pkg::FAULT_NONE;
        chg   = 1'b0;
        r.row = '0;
        case (rvm_pkg::op_t'(operation))
            rvm_pkg::OP_EXEC:  run_opcode(opcode, random_byte, flt, chg);
            rvm_pkg::OP_WRITE: memory[address] = write_data;
            rvm_pkg::OP_TICK:
            begin
                if (delay_cnt != 0)
                    delay_cnt--;
                if (sound_cnt != 0)
                    sound_cnt--;
            end
            default:
                if (address < rvm_pkg::SCREEN_HEIGHT)
                    r.row = screen[address[4:0]];
        endcase
        r.pc  = pc_reg;
        r.flt = flt;
        r.snd = sound_cnt != 0;
        r.chg = chg;
        pending_results.push_back(r);
    endtask

    task automatic check_result();
        core_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result", 64'(program_counter), 64'd0);
            return;
        end
        want = pending_results.pop_front();
        if (program_counter !== want.pc)
            report_mismatch("program_counter", 64'(program_counter), 64'(want.pc));
        if (fault !== want.flt)
            report_mismatch("fault", 64'(fault), 64'(want.flt));
        if (row_pixels !== want.row)
            report_mismatch("row_pixels", row_pixels, want.row);
        if (sound_on !== want.snd)
            report_mismatch("sound_on", 64'(sound_on), 64'(want.snd));
        if (screen_changed !== want.chg)
            report_mismatch("screen_changed", 64'(screen_changed), 64'(want.chg));
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // Check the outgoing result before predicting a transfer in the same cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++)
                vregs[k] = '0;
            for (int k = 0; k < rvm_pkg::SCREEN_HEIGHT; k++)
                screen[k] = '0;
            index_reg   = '0;
            pc_reg      = 12'h200;
            stack_depth = 0;
            delay_cnt   = '0;
            sound_cnt   = '0;
        end
        else
        begin
            if (done)
                check_result();
            if (start && !busy)
                predict_item();
            pending = pending_results.size();
        end
    end

endmodule

FILE: bench/retro_vm_instruction_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retro_vm_instruction_core_tb: stimulus and verdict for the instruction core
// Drives directed then random opcodes, memory writes, timer ticks and row
// reads with random gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module retro_vm_instruction_core_tb;

    localparam int ITEM_TARGET = 950;
    localparam int CYCLE_LIMIT = 600000;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    rvm_pkg::op_t  operation;
    logic [15:0]   opcode;
    logic [7:0]    random_byte;
    logic [11:0]   address;
    logic [7:0]    write_data;
    logic          done;
    logic [11:0]   program_counter;
    logic [1:0]    fault;
    logic [63:0]   row_pixels;
    logic          sound_on;
    logic          screen_changed;
    int            errors;
    int            pending;
    int            cycles;
    int            items_sent;
    bit            mem_written [rvm_pkg::MEM_DEPTH];

    retro_vm_instruction_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .opcode          (opcode),
        .random_byte     (random_byte),
        .address         (address),
        .write_data      (write_data),
        .done            (done),
        .program_counter (program_counter),
        .fault           (fault),
        .row_pixels      (row_pixels),
        .sound_on        (sound_on),
        .screen_changed  (screen_changed)
    );

    retro_vm_core_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .opcode          (opcode),
        .random_byte     (random_byte),
        .address         (address),
        .write_data      (write_data),
        .done            (done),
        .program_counter (program_counter),
        .fault           (fault),
        .row_pixels      (row_pixels),
        .sound_on        (sound_on),
        .screen_changed  (screen_changed),
        .errors          (errors),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[retro_vm_instruction_core] ERROR");
            $finish;
        end
    end

    // Present one item and hold it until the transfer
    task automatic send_item(input rvm_pkg::op_t op, input logic [15:0] opc,
                             input logic [11:0] addr, input logic [7:0] wdata);
        @(negedge clk);
        start       <= 1'b1;
        operation   <= op;
        opcode      <= opc;
        random_byte <= 8'($urandom);
        address     <= addr;
        write_data  <= wdata;
        do
            @(posedge clk);
        while (busy);
        // let the checker take the transfer in before the next item looks at it
        #1;
        items_sent++;
    endtask

    // Drop start for a random stretch, mostly short, sometimes none
    task automatic idle_gap();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic write_byte(input logic [11:0] addr, input logic [7:0] data);
        send_item(rvm_pkg::OP_WRITE, 16'($urandom), addr, data);
        mem_written[addr] = 1'b1;
        idle_gap();
    endtask

    // Fill any bytes a memory read would touch that were never written
    task automatic cover_memory(input logic [15:0] base, input int count);
        logic [11:0] a;
        for (int k = 0; k < count; k++)
        begin
            a = base[11:0] + 12'(k);
            if (!mem_written[a])
                write_byte(a, 8'($urandom));
        end
    endtask

    task automatic exec_opcode(input logic [15:0] opc);
        logic [15:0] ibase;
        int          span;
        ibase = chk.index_reg;
        span  = int'(opc[11:8]) + 1;
        if (opc[15:12] == 4'hD)
            cover_memory(ibase, int'(opc[3:0]));
        if (opc[15:12] == 4'hF && opc[7:0] == 8'h65)
            cover_memory(ibase, span);
        send_item(rvm_pkg::OP_EXEC, opc, 12'($urandom), 8'($urandom));
        // record bytes the core stores itself
        if (opc[15:12] == 4'hF && opc[7:0] == 8'h33)
            for (int k = 0; k < 3; k++)
                mem_written[ibase[11:0] + 12'(k)] = 1'b1;
        if (opc[15:12] == 4'hF && opc[7:0] == 8'h55)
            for (int k = 0; k < span; k++)
                mem_written[ibase[11:0] + 12'(k)] = 1'b1;
        idle_gap();
    endtask

    function automatic logic [15:0] random_opcode();
        logic [15:0] r;
        logic [7:0]  f_sel [10];
        int          pick;
        f_sel = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55,
                  8'h65, 8'h00};
        r     = 16'($urandom);
        pick  = $urandom_range(0, 99);
        if (pick < 4)
            return 16'h00E0;
        if (pick < 8)
            return 16'h00EE;
        if (pick < 10)
            return {4'h0, r[11:0]};
        if (pick < 16)
            return {4'h8, r[11:4], 4'($urandom_range(0, 7))};
        if (pick < 20)
            return {4'h8, r[11:4], 4'hE};
        if (pick < 24)
            return {4'h8, r[11:4], r[3:0]};
        if (pick < 34)
            return {4'hD, r[11:4], 4'($urandom_range(0, 6))};
        if (pick < 36)
            return {4'hD, r[11:0]};
        if (pick < 40)
            return {4'hE, r[11:8], ($urandom_range(0, 1) ? 8'h9E : 8'hA1)};
        if (pick < 42)
            return {4'hE, r[11:0]};
        if (pick < 58)
        begin
            r[7:0] = f_sel[$urandom_range(0, 8)];
            if ($urandom_range(0, 15) == 0)
                r[7:0] = 8'($urandom);
            return {4'hF, r[11:0]};
        end
        if (pick < 66)
            return {($urandom_range(0, 1) ? 4'h5 : 4'h9), r[11:4],
                    ($urandom_range(0, 3) == 0 ? r[3:0] : 4'h0)};
        if (pick < 72)
            return {4'($urandom_range(3, 4)), r[11:0]};
        if (pick < 88)
            return {4'($urandom_range(6, 7)), r[11:0]};
        if (pick < 94)
            return {4'($urandom_range(10, 12)), r[11:0]};
        return {4'($urandom_range(1, 2)), r[11:0]};
    endfunction

    // Nested calls, sometimes past the stack depth, then unwind one too far
    task automatic call_burst();
        int levels;
        levels = $urandom_range(1, rvm_pkg::STACK_DEPTH + 2);
        for (int k = 0; k < levels; k++)
            exec_opcode({4'h2, 12'($urandom)});
        for (int k = 0; k <= levels; k++)
            exec_opcode(16'h00EE);
    endtask

    initial
    begin
        int pick;
        bit drained;
        cycles      = 0;
        items_sent  = 0;
        drained     = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        operation   = rvm_pkg::OP_EXEC;
        opcode      = '0;
        random_byte = '0;
        address     = '0;
        write_data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, flag as target, wrap cases, faults
        exec_opcode(16'h00EE);
        exec_opcode(16'h60FF);
        exec_opcode(16'h6101);
        exec_opcode(16'h8014);
        exec_opcode(16'h6FFF);
        exec_opcode(16'h8F15);
        exec_opcode(16'h8017);
        exec_opcode(16'h820E);
        exec_opcode(16'h8F06);
        exec_opcode(16'hF029);
        exec_opcode(16'hD01F);
        exec_opcode(16'hD010);
        exec_opcode(16'hAFFE);
        exec_opcode(16'hF033);
        exec_opcode(16'hFF55);
        exec_opcode(16'hFF65);
        exec_opcode(16'hA000);
        exec_opcode(16'hD00F);
        send_item(rvm_pkg::OP_READ, 16'hFFFF, 12'd0, 8'hFF);
        send_item(rvm_pkg::OP_READ, 16'h0000, 12'hFFF, 8'h00);
        exec_opcode(16'hF018);
        send_item(rvm_pkg::OP_TICK, 16'h0000, 12'h000, 8'h00);
        exec_opcode(16'hEEA1);
        exec_opcode(16'h00E0);
        exec_opcode(16'h0123);
        exec_opcode(16'hBFFF);

        // Random: mostly opcodes, with writes, ticks and row reads mixed in
        while (items_sent < ITEM_TARGET)
        begin
            // once, halfway: hold off until every result is back
            if (!drained && items_sent > ITEM_TARGET / 2)
            begin
                drained = 1'b1;
                @(negedge clk);
                start <= 1'b0;
                while (pending != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
                call_burst();
            else if (pick < 60)
                exec_opcode(random_opcode());
            else if (pick < 72)
                write_byte(12'($urandom), 8'($urandom));
            else if (pick < 82)
            begin
                send_item(rvm_pkg::OP_TICK, 16'($urandom), 12'($urandom), 8'($urandom));
                idle_gap();
            end
            else
            begin
                send_item(rvm_pkg::OP_READ, 16'($urandom),
                          ($urandom_range(0, 9) == 0 ? 12'($urandom)
                                                     : 12'($urandom_range(0, 31))),
                          8'($urandom));
                idle_gap();
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("[retro_vm_instruction_core] OK");
        else
            $display("[retro_vm_instruction_core] ERROR");
        $finish;
    end

endmodule

FILE: retro_vm_instruction_core.f
src/rvm_pkg.sv
src/rvm_datapath.sv
src/rvm_ctrl.sv
src/retro_vm_instruction_core.sv
bench/retro_vm_core_checker.sv
bench/retro_vm_instruction_core_tb.sv
